// File: rtl/pc_pkg.sv
// shared types and constants for the pearson correlation block
package pc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_SAMPLES  = 4096;
    localparam int CNT_W        = 13;
    localparam int SUM_W        = 28;
    localparam int SQ_W         = 43;
    localparam int DIFF_W       = 57;
    localparam int MA_W         = 112;
    localparam int MB_W         = 56;
    localparam int PROD_W       = MA_W + MB_W;
    localparam int Q_W          = 15;
    localparam int BIT_W        = 4;
    localparam int ROUND_SHIFT  = 30;
    localparam int CORR_W       = 16;

    typedef enum logic [3:0] {
        OP_NSXY,
        OP_SXSY,
        OP_NSXX,
        OP_SXSX,
        OP_NSYY,
        OP_SYSY,
        OP_VXVY,
        OP_NUM2,
        OP_ODD,
        OP_TEST
    } op_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_ISSUE,
        ST_WAIT,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             start;
        logic             commit;
        logic             load_out;
        op_t              op;
        logic [BIT_W-1:0] bit_idx;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic degen;
    } status_t;

endpackage

// File: rtl/pc_mul.sv
// shift-add multiplier, one multiplier bit per cycle, stops when no bits remain
module pc_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pc_pkg::MA_W-1:0]    a,
    input  logic [pc_pkg::MB_W-1:0]    b,
    output logic                       done,
    output logic [pc_pkg::PROD_W-1:0]  prod
);
    import pc_pkg::*;

    logic              busy_reg, busy_next;
    logic [PROD_W-1:0] a_reg, a_next;
    logic [MB_W-1:0]   b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;

    assign done = busy_reg && (b_reg == '0);
    assign prod = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = {{(PROD_W-MA_W){1'b0}}, a};
            b_next    = b;
            acc_next  = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = {a_reg[PROD_W-2:0], 1'b0};
            b_next = {1'b0, b_reg[MB_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

// File: rtl/pc_datapath.sv
// accumulators, shared multiplier, root search registers and result register
module pc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pc_pkg::cmd_t                      cmd,
    output pc_pkg::status_t                   status,
    input  logic signed [15:0]                x_value,
    input  logic signed [15:0]                y_value,
    output logic signed [pc_pkg::CORR_W-1:0]  correlation,
    output logic                              degenerate,
    output logic                              overflow,
    output logic [pc_pkg::CNT_W-1:0]          sample_count
);
    import pc_pkg::*;

    logic [CNT_W-1:0]         n_reg;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg;
    logic [SQ_W-1:0]          sxx_reg, syy_reg;
    // one extra bit: a full set of the most negative sample sums to 2^42
    logic signed [SQ_W:0]     sxy_reg;
    logic                     ovf_reg;

    logic signed [DIFF_W-1:0] t_reg, num_reg, vx_reg, vy_reg;
    logic [MA_W-1:0]          p_reg;
    logic [PROD_W-1:0]        r_reg;
    logic [MB_W-1:0]          sq_reg;
    logic [Q_W-1:0]           q_reg;

    logic signed [CORR_W-1:0] corr_reg;
    logic                     deg_reg, ovf_out_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic signed [SAMPLE_WIDTH-1:0] xs, ys;
    logic signed [2*SAMPLE_WIDTH-1:0] xx, yy, xy;

    logic [SUM_W-1:0]   sx_abs, sy_abs;
    logic [MB_W-1:0]    sxy_abs, num_abs;
    logic [DIFF_W-1:0]  num_neg;
    logic [Q_W-1:0]     cand;
    logic [Q_W:0]       odd;

    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic               neg;
    logic               mul_done;
    logic [PROD_W-1:0]  prod;
    logic signed [DIFF_W-1:0] sp, spn;

    assign xs = x_value[SAMPLE_WIDTH-1:0];
    assign ys = y_value[SAMPLE_WIDTH-1:0];
    assign xx = xs * xs;
    assign yy = ys * ys;
    assign xy = xs * ys;

    assign sx_abs  = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
    assign sy_abs  = sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : SUM_W'(sy_reg);
    assign sxy_abs = sxy_reg[SQ_W] ? MB_W'(-sxy_reg) : MB_W'(sxy_reg);
    assign num_neg = -num_reg;
    assign num_abs = num_reg[DIFF_W-1] ? num_neg[MB_W-1:0] : num_reg[MB_W-1:0];

    assign cand = q_reg | (Q_W'(1) << cmd.bit_idx);
    assign odd  = {cand, 1'b0} - (Q_W+1)'(1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        neg   = 1'b0;
        unique case (cmd.op)
            OP_NSXY:
            begin
                mul_a = MA_W'(n_reg);
                mul_b = sxy_abs;
                neg   = sxy_reg[SQ_W];
            end
            OP_SXSY:
            begin
                mul_a = MA_W'(sx_abs);
                mul_b = MB_W'(sy_abs);
                neg   = sx_reg[SUM_W-1] ^ sy_reg[SUM_W-1];
            end
            OP_NSXX:
            begin
                mul_a = MA_W'(n_reg);
                mul_b = MB_W'(sxx_reg);
            end
            OP_SXSX:
            begin
                mul_a = MA_W'(sx_abs);
                mul_b = MB_W'(sx_abs);
            end
            OP_NSYY:
            begin
                mul_a = MA_W'(n_reg);
                mul_b = MB_W'(syy_reg);
            end
            OP_SYSY:
            begin
                mul_a = MA_W'(sy_abs);
                mul_b = MB_W'(sy_abs);
            end
            OP_VXVY:
            begin
                mul_a = MA_W'(vx_reg[MB_W-1:0]);
                mul_b = vy_reg[MB_W-1:0];
            end
            OP_NUM2:
            begin
                mul_a = MA_W'(num_abs);
                mul_b = num_abs;
            end
            OP_ODD:
            begin
                mul_a = MA_W'(odd);
                mul_b = MB_W'(odd);
            end
            OP_TEST:
            begin
                mul_a = p_reg;
                mul_b = sq_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    assign sp  = {1'b0, prod[DIFF_W-2:0]};
    assign spn = neg ? -sp : sp;

    assign status.mul_done = mul_done;
    assign status.degen    = (vx_reg <= 0) || (vy_reg <= 0);

    // sample accumulators, cleared when the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            ovf_reg <= 1'b0;
            q_reg   <= '0;
        end
        else if (cmd.load_out)
        begin
            n_reg   <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            ovf_reg <= 1'b0;
            q_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (n_reg < CNT_W'(MAX_SAMPLES))
                begin
                    n_reg   <= n_reg + CNT_W'(1);
                    sx_reg  <= sx_reg + SUM_W'(xs);
                    sy_reg  <= sy_reg + SUM_W'(ys);
                    sxx_reg <= sxx_reg + SQ_W'(unsigned'(xx));
                    syy_reg <= syy_reg + SQ_W'(unsigned'(yy));
                    sxy_reg <= sxy_reg + (SQ_W+1)'(xy);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.commit && cmd.op == OP_TEST && prod <= r_reg)
            begin
                q_reg <= cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            unique case (cmd.op)
                OP_NSXY, OP_NSXX, OP_NSYY: t_reg <= spn;
                OP_SXSY: num_reg <= t_reg - spn;
                OP_SXSX: vx_reg <= t_reg - spn;
                OP_SYSY: vy_reg <= t_reg - spn;
                OP_VXVY: p_reg <= prod[MA_W-1:0];
                OP_NUM2: r_reg <= {prod[PROD_W-1-ROUND_SHIFT:0], {ROUND_SHIFT{1'b0}}};
                OP_ODD:  sq_reg <= prod[MB_W-1:0];
                OP_TEST: ;
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            corr_reg    <= num_reg[DIFF_W-1] ? -CORR_W'(q_reg) : CORR_W'(q_reg);
            deg_reg     <= status.degen;
            ovf_out_reg <= ovf_reg;
            cnt_reg     <= n_reg;
        end
    end

    assign correlation  = corr_reg;
    assign degenerate   = deg_reg;
    assign overflow     = ovf_out_reg;
    assign sample_count = cnt_reg;

endmodule

// File: rtl/pc_ctrl.sv
// controller: accumulate phase, multiply sequence, root search and output handshake
module pc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    output pc_pkg::cmd_t    cmd,
    input  pc_pkg::status_t status
);
    import pc_pkg::*;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        bit_next     = bit_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.start    = 1'b0;
        cmd.commit   = 1'b0;
        cmd.load_out = 1'b0;
        cmd.op       = op_reg;
        cmd.bit_idx  = bit_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    op_next    = OP_NSXY;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_ISSUE;
                    unique case (op_reg)
                        OP_NSXY: op_next = OP_SXSY;
                        OP_SXSY: op_next = OP_NSXX;
                        OP_NSXX: op_next = OP_SXSX;
                        OP_SXSX: op_next = OP_NSYY;
                        OP_NSYY: op_next = OP_SYSY;
                        OP_SYSY: state_next = ST_CHECK;
                        OP_VXVY: op_next = OP_NUM2;
                        OP_NUM2:
                        begin
                            op_next  = OP_ODD;
                            bit_next = BIT_W'(Q_W - 1);
                        end
                        OP_ODD:  op_next = OP_TEST;
                        OP_TEST:
                        begin
                            if (bit_reg == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                bit_next = bit_reg - BIT_W'(1);
                                op_next  = OP_ODD;
                            end
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_CHECK:
            begin
                // zero variance skips the root search, q stays zero
                if (status.degen)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    op_next    = OP_VXVY;
                    state_next = ST_ISSUE;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            op_reg        <= OP_NSXY;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> state_reg == ST_WAIT)
        else $error("multiplier finished outside wait state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten while full");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BIT_W'(Q_W - 1))
        else $error("search bit index out of range");

    a_issue_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |=> state_reg == ST_WAIT)
        else $error("issue not followed by wait");

endmodule

// File: rtl/pearson_correlation_top.sv
// pearson correlation top level: stream ports, controller and datapath
//
// input stream s_*: one (x, y) sample pair per transfer, s_tlast marks the
// final pair of a data set. pairs accumulate at one per cycle in ST_ACCUM.
// output stream m_*: one result per data set, the correlation in signed
// Q2.14 with degenerate and overflow flags and the number of pairs used.
// after the last pair, s_tready drops while the result is computed on one
// shared shift-add multiplier that retires one multiplier bit per cycle:
// six products form the covariance and variance terms, two more form the
// squared terms, then fifteen compare steps find the rounded quotient bit
// by bit. the multiply chain dominates; the time from the last transfer to
// m_tvalid is data dependent.
// pairs beyond 4096 in one set are dropped and flagged.
// a finished result sits in the output register; accumulation of the next
// set resumes at once, and a new result waits only if the previous one has
// not been taken when it is ready.
// reset clears the accumulators and the output valid flag.
module pearson_correlation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_value[15:0], y_value[31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // correlation[15:0], sample_count[28:16]
    output logic [1:0]  m_tuser    // degenerate[0], overflow[1]
);
    import pc_pkg::*;

    cmd_t                     cmd;
    status_t                  status;
    logic signed [CORR_W-1:0] correlation;
    logic                     degenerate;
    logic                     overflow;
    logic [CNT_W-1:0]         sample_count;

    pc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    pc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .x_value      (s_tdata[15:0]),
        .y_value      (s_tdata[31:16]),
        .correlation  (correlation),
        .degenerate   (degenerate),
        .overflow     (overflow),
        .sample_count (sample_count)
    );

    assign m_tdata = {3'b000, sample_count, correlation};
    assign m_tuser = {overflow, degenerate};

endmodule

// File: bench/tb_pearson_correlation_top.sv
// testbench for the pearson correlation block: random and directed pair streams
`timescale 1ns / 100ps

module tb_pearson_correlation_top;

    import pc_pkg::*;

    typedef struct {
        logic signed [15:0] corr;
        logic               degen;
        logic               ovf;
        logic [12:0]        count;
    } corr_result_t;

    class corr_scoreboard;
        int                 n_pairs;
        longint             sx, sy, sxx, syy, sxy;
        bit                 ovf_seen;
        corr_result_t       pending[$];
        int                 errors;
        int                 sets_checked;

        function new();
            clear_sums();
            errors = 0;
            sets_checked = 0;
        endfunction

        function void clear_sums();
            n_pairs = 0;
            sx = 0;
            sy = 0;
            sxx = 0;
            syy = 0;
            sxy = 0;
            ovf_seen = 0;
        endfunction

        // largest q <= 16384 with (2q-1)^2 * vx * vy <= 2^30 * mag^2
        function int rounded_ratio(longint unsigned mag, longint unsigned vx,
                                   longint unsigned vy);
            logic [191:0] prod;
            logic [191:0] rhs;
            logic [191:0] lhs;
            int           lo;
            int           hi;
            int           mid;
            longint       odd;
            prod = 192'(vx) * 192'(vy);
            rhs  = (192'(mag) * 192'(mag)) << 30;
            lo = 0;
            hi = 16384;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                odd = 2 * mid - 1;
                lhs = 192'(odd * odd) * prod;
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
            longint       n;
            longint       num;
            longint       vx;
            longint       vy;
            int           q;
            corr_result_t r;
            if (n_pairs < MAX_SAMPLES) begin
                n_pairs++;
                sx  += x;
                sy  += y;
                sxx += longint'(x) * x;
                syy += longint'(y) * y;
                sxy += longint'(x) * y;
            end else begin
                ovf_seen = 1;
            end
            if (!last) return;
            n   = n_pairs;
            num = n * sxy - sx * sy;
            vx  = n * sxx - sx * sx;
            vy  = n * syy - sy * sy;
            r.degen = (vx <= 0) || (vy <= 0);
            r.corr  = 0;
            if (!r.degen) begin
                q = rounded_ratio((num < 0) ? -num : num, vx, vy);
                r.corr = (num < 0) ? -q : q;
            end
            r.ovf   = ovf_seen;
            r.count = n_pairs;
            pending.push_back(r);
            clear_sums();
        endfunction

        function void check_result(logic [31:0] data, logic [1:0] user);
            corr_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result data=%h user=%b", $time, data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            sets_checked++;
            if (data[15:0] !== e.corr) begin
                $display("%0t: correlation expected %0d actual %0d", $time, e.corr,
                         $signed(data[15:0]));
                errors++;
            end
            if (data[28:16] !== e.count) begin
                $display("%0t: sample_count expected %0d actual %0d", $time, e.count,
                         data[28:16]);
                errors++;
            end
            if (user[0] !== e.degen) begin
                $display("%0t: degenerate expected %b actual %b", $time, e.degen, user[0]);
                errors++;
            end
            if (user[1] !== e.ovf) begin
                $display("%0t: overflow expected %b actual %b", $time, e.ovf, user[1]);
                errors++;
            end
            if (data[31:29] !== 3'b000) begin
                $display("%0t: pad bits expected 0 actual %b", $time, data[31:29]);
                errors++;
            end
        endfunction
    endclass

    localparam int LIMIT_CYCLES = 3_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    corr_scoreboard scb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  cycle_count;
    int  pairs_sent;

    pearson_correlation_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                scb.check_result(m_tdata, m_tuser);
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // one pair transfer; idles at random before offering, valid stays up after
    task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        scb.note_pair(x, y, last);
        pairs_sent++;
    endtask

    function automatic logic [15:0] rand_sample(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(40)) - 20);
            2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(2000)) - 16'd1000;
        endcase
    endfunction

    // a data set of len pairs with a random flavor of correlation
    task automatic send_set(int len);
        int          mode;
        int          kind;
        logic [15:0] x;
        logic [15:0] y;
        mode = $urandom_range(3);
        kind = $urandom_range(4);
        for (int i = 0; i < len; i++)
        begin
            x = rand_sample(mode);
            case (kind)
                0: y = x;
                1: y = -x;
                2: y = x + 16'($urandom_range(6)) - 16'd3;
                3: y = 16'd5;
                default: y = rand_sample(mode);
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (scb.pending.size() != 0) @(posedge clk);
        repeat (1300) @(posedge clk);
    endtask

    initial
    begin
        scb = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        pairs_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: single pair, two pairs, extremes, perfect and anti correlation
        send_pair(16'sh7fff, 16'sh8000, 1);
        send_pair(16'sh8000, 16'sh7fff, 0);
        send_pair(16'sh7fff, 16'sh8000, 1);
        send_pair(16'sh8000, 16'sh8000, 0);
        send_pair(16'sh7fff, 16'sh7fff, 1);
        send_pair(1, 2, 0);
        send_pair(2, 4, 0);
        send_pair(3, 7, 1);
        send_pair(16'hffff, 16'haaaa, 0);
        send_pair(16'h0000, 16'h5555, 0);
        send_pair(16'h1234, 16'h0000, 1);
        send_pair(0, 0, 0);
        send_pair(0, 0, 1);
        send_pair(5, 1, 0);
        send_pair(5, 9, 1);
        send_pair(-3, 1, 0);
        send_pair(3, 1, 1);

        // long receiver hold-off while pairs keep coming
        hold_cycles = 4000;
        for (int s = 0; s < 6; s++) send_set(3);
        drain();

        // overflow: 4097 pairs with last on the extra one, once
        for (int i = 0; i < MAX_SAMPLES; i++)
            send_pair(16'($urandom), 16'($urandom), 0);
        send_pair(16'sh7fff, 16'sh7fff, 1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 20 : 52) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 20 : 52) : 0;
            while (pairs_sent < 17 + 18 + 4097 + (phase + 1) * 112)
                send_set($urandom_range(1, 8));
        end

        drain();
        $display("checked %0d result sets from %0d pair transfers", scb.sets_checked,
                 pairs_sent);
        $display("covered extremes, degenerate sets, sample bound and stall phases");
        if (scb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
